// ===== design/assert_macros.svh =====
// shared assertion macros for the color classifier checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define RHCC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rhcc check failed");

// same-cycle implication
`define RHCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rhcc implication failed");

// next-cycle implication
`define RHCC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rhcc next-cycle check failed");

`endif

// ===== design/rhcc_pkg.sv =====
package rhcc_pkg;

  // field widths
  localparam int ChanW = 8;
  localparam int DistW = 9;
  localparam int HueW  = 13;
  localparam int ClsW  = 2;

  // hue times delta, below 360 * 255
  localparam int HdW   = 17;
  // partial remainder, always below the 8-bit divisor
  localparam int RemW  = ChanW;

  // one quotient bit per cell, both quotients fit in the hue width
  localparam int NumCells = HueW;

  // near and dark thresholds
  localparam logic [DistW-1:0] NearDist = 9'd192;
  localparam logic [ChanW-1:0] DarkAmb  = 8'd200;

  // hue band edges in degrees
  localparam int HueGreenLo = 85;
  localparam int HueGreenHi = 165;
  localparam int HueBlueLo  = 175;
  localparam int HueBlueHi  = 270;
  localparam int HueRedHi   = 330;
  localparam int HueRedLo   = 30;

  // sextant base angles and scaling
  localparam int HueGreenBase = 120;
  localparam int HueBlueBase  = 240;
  localparam int HueFull      = 360;
  localparam int HueStep      = 60;
  localparam int SatScale     = 255;

  typedef enum logic [ClsW-1:0] {
    CLS_NONE  = 2'd0,
    CLS_RED   = 2'd1,
    CLS_GREEN = 2'd2,
    CLS_BLUE  = 2'd3
  } cls_e;

  typedef enum logic [1:0] {
    SEXT_RED,
    SEXT_GREEN,
    SEXT_BLUE
  } sext_e;

  // one restoring division in flight: remainder, shift word, divisor
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [HueW-1:0] sh;
    logic [RemW-1:0] den;
  } quo_t;

  // data handed from cell to cell
  typedef struct packed {
    quo_t             hue;
    quo_t             sat;
    logic [ChanW-1:0] value;
    cls_e             cls;
  } cell_t;

endpackage

// ===== design/rhcc_if.sv =====
// input beat: one color reading
interface rhcc_in_if;
  import rhcc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic [DistW-1:0] distance;
  logic [ChanW-1:0] ambient;

  modport source (output valid, red, green, blue, distance, ambient, input ready);
  modport sink   (input valid, red, green, blue, distance, ambient, output ready);
endinterface

// output beat: hsv and class
interface rhcc_out_if;
  import rhcc_pkg::*;
  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] saturation;
  logic [ChanW-1:0] value;
  logic [ClsW-1:0]  color_class;

  modport source (output valid, hue, saturation, value, color_class, input ready);
  modport sink   (input valid, hue, saturation, value, color_class, output ready);
endinterface

// ===== design/rhcc_prep.sv =====
module rhcc_prep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rhcc_pkg::ChanW-1:0] red_i,
  input  logic [rhcc_pkg::ChanW-1:0] green_i,
  input  logic [rhcc_pkg::ChanW-1:0] blue_i,
  input  logic [rhcc_pkg::DistW-1:0] distance_i,
  input  logic [rhcc_pkg::ChanW-1:0] ambient_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rhcc_pkg::cell_t           out_data_o
);
  import rhcc_pkg::*;

  // stage valids and per-stage acceptance
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // stage 1 registers
  logic [ChanW-1:0]  s1_mx_q, s1_delta_q;
  logic signed [ChanW:0] s1_diff_q;
  sext_e             s1_sext_q;
  logic              s1_near_q;

  // stage 2 registers
  logic [HdW-1:0]    s2_hd_q;
  logic [ChanW-1:0]  s2_mx_q, s2_delta_q;
  logic              s2_near_q;

  // stage 3 register
  cell_t             s3_q;

  // stage 1 logic
  logic [ChanW-1:0]  mx_d, mn_d;
  logic signed [ChanW:0] diff_d;
  sext_e             sext_d;

  // stage 2 logic
  logic [HdW-1:0]    base_d;
  logic signed [HdW:0] hd60_d, hd_raw_d, hd_wrap_d;
  logic [HdW-1:0]    hd_d;

  // stage 3 logic
  logic [HdW-1:0]    dlt17;
  logic [HueW+7:0]   num_h;
  logic [15:0]       num_s;
  logic              sat_low, band_green, band_blue, band_red;
  cell_t             s3_d;

  // elastic handshake along the three stages
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // max, min and sextant pick, red wins ties then green
  always_comb begin
    mx_d = (red_i > green_i) ? red_i : green_i;
    mn_d = (red_i < green_i) ? red_i : green_i;
    if (blue_i > mx_d) mx_d = blue_i;
    if (blue_i < mn_d) mn_d = blue_i;
    if (red_i >= mx_d) begin
      sext_d = SEXT_RED;
      diff_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= mx_d) begin
      sext_d = SEXT_GREEN;
      diff_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sext_d = SEXT_BLUE;
      diff_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_mx_q    <= mx_d;
      s1_delta_q <= mx_d - mn_d;
      s1_diff_q  <= diff_d;
      s1_sext_q  <= sext_d;
      s1_near_q  <= (distance_i < NearDist) && (ambient_i < DarkAmb);
    end
  end

  // hue times delta, wrapped into one turn
  always_comb begin
    case (s1_sext_q)
      SEXT_GREEN: base_d = HdW'(HueGreenBase) * HdW'(s1_delta_q);
      SEXT_BLUE:  base_d = HdW'(HueBlueBase) * HdW'(s1_delta_q);
      default:    base_d = '0;
    endcase
    hd60_d    = $signed((HdW+1)'(HueStep)) * (HdW+1)'(s1_diff_q);
    hd_raw_d  = $signed({1'b0, base_d}) + hd60_d;
    hd_wrap_d = hd_raw_d + $signed({1'b0, HdW'(HueFull) * HdW'(s1_delta_q)});
    hd_d      = hd_raw_d[HdW] ? hd_wrap_d[HdW-1:0] : hd_raw_d[HdW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_hd_q    <= hd_d;
      s2_mx_q    <= s1_mx_q;
      s2_delta_q <= s1_delta_q;
      s2_near_q  <= s1_near_q;
    end
  end

  // class decision on exact rationals, division set-up
  always_comb begin
    dlt17      = HdW'(s2_delta_q);
    sat_low    = {s2_delta_q, 1'b0} < {1'b0, s2_mx_q};
    band_green = (s2_hd_q > HdW'(HueGreenLo) * dlt17) && (s2_hd_q < HdW'(HueGreenHi) * dlt17);
    band_blue  = (s2_hd_q > HdW'(HueBlueLo) * dlt17) && (s2_hd_q < HdW'(HueBlueHi) * dlt17);
    band_red   = (s2_hd_q > HdW'(HueRedHi) * dlt17) || (s2_hd_q < HdW'(HueRedLo) * dlt17);

    num_h = {s2_hd_q, 4'b0000};
    num_s = 16'(SatScale) * 16'(s2_delta_q);

    s3_d.value = s2_mx_q;
    if (s2_delta_q == '0 || sat_low || s2_near_q) s3_d.cls = CLS_NONE;
    else if (band_green)                          s3_d.cls = CLS_GREEN;
    else if (band_blue)                           s3_d.cls = CLS_BLUE;
    else if (band_red)                            s3_d.cls = CLS_RED;
    else                                          s3_d.cls = CLS_NONE;

    // quotient fits in HueW bits, so the top part starts below the divisor
    s3_d.hue.rem = num_h[HueW+7:HueW];
    s3_d.hue.sh  = num_h[HueW-1:0];
    s3_d.sat.rem = RemW'(num_s[15:HueW]);
    s3_d.sat.sh  = num_s[HueW-1:0];
    // grey: zero numerators over one give zero fields
    s3_d.hue.den = (s2_delta_q == '0) ? RemW'(1) : s2_delta_q;
    s3_d.sat.den = (s2_delta_q == '0) ? RemW'(1) : s2_mx_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) s3_q <= s3_d;
  end

endmodule

// ===== design/rhcc_div_cell.sv =====
module rhcc_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rhcc_pkg::cell_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rhcc_pkg::cell_t out_data_o
);
  import rhcc_pkg::*;

  logic  valid_q;
  cell_t data_q;
  cell_t data_d;

  // one restoring step: shift in next numerator bit, trial subtract
  function automatic quo_t div_step(input quo_t q);
    logic [RemW:0] trial;
    logic          ge;
    quo_t          r;
    trial  = {q.rem, q.sh[HueW-1]};
    ge     = trial >= {1'b0, q.den};
    r.den  = q.den;
    r.rem  = ge ? RemW'(trial - {1'b0, q.den}) : trial[RemW-1:0];
    r.sh   = {q.sh[HueW-2:0], ge};
    return r;
  endfunction

  always_comb begin
    data_d       = in_data_i;
    data_d.hue   = div_step(in_data_i.hue);
    data_d.sat   = div_step(in_data_i.sat);
  end

  // cell handshake, holds its beat while downstream stalls
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) data_q <= data_d;
  end

endmodule

// ===== design/rgb_hsv_color_classifier_unit.sv =====
// channel | dir | payload                                  | handshake
// in_i    | in  | red, green, blue, distance, ambient      | valid/ready
// out_o   | out | hue, saturation, value, color_class      | valid/ready
//
// one beat per cycle sustained while out_o is ready; 3 setup stages + 13 divider cells
// the divider cells each retire one quotient bit of both hue and saturation
// reset clears the stage valid flags only; payload registers are not reset
// every stage holds its beat under backpressure and empty stages fill in behind it
module rgb_hsv_color_classifier_unit (
  input logic      clk_i,
  input logic      rst_ni,
  rhcc_in_if.sink  in_i,
  rhcc_out_if.source out_o
);
  import rhcc_pkg::*;

  cell_t chain [NumCells+1];
  logic  valid [NumCells+1];
  logic  ready [NumCells+1];

  // min/max, hue sextant and class
  rhcc_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .red_i       (in_i.red),
    .green_i     (in_i.green),
    .blue_i      (in_i.blue),
    .distance_i  (in_i.distance),
    .ambient_i   (in_i.ambient),
    .out_valid_o (valid[0]),
    .out_ready_i (ready[0]),
    .out_data_o  (chain[0])
  );

  // divider row, one quotient bit per cell
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rhcc_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[k]),
      .in_ready_o  (ready[k]),
      .in_data_i   (chain[k]),
      .out_valid_o (valid[k+1]),
      .out_ready_i (ready[k+1]),
      .out_data_o  (chain[k+1])
    );
  end

  // last cell register drives the output beat
  assign ready[NumCells]   = out_o.ready;
  assign out_o.valid       = valid[NumCells];
  assign out_o.hue         = chain[NumCells].hue.sh;
  assign out_o.saturation  = chain[NumCells].sat.sh[ChanW-1:0];
  assign out_o.value       = chain[NumCells].value;
  assign out_o.color_class = chain[NumCells].cls;

endmodule

// ===== design/rhcc_checker.sv =====
`include "assert_macros.svh"

module rhcc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rhcc_pkg::HueW-1:0]  hue_i,
  input logic [rhcc_pkg::ChanW-1:0] saturation_i,
  input logic [rhcc_pkg::ChanW-1:0] value_i,
  input logic [rhcc_pkg::ClsW-1:0]  color_class_i
);
  import rhcc_pkg::*;

  // a stalled result beat keeps its hue, saturation and class
  `RHCC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(hue_i) && $stable(saturation_i) && $stable(color_class_i))

  // an offered beat only waits when the whole row is full and the output stalls
  `RHCC_ASSERT_IMP(a_in_block, clk_i, rst_ni, in_valid_i && !in_ready_i, out_valid_i && !out_ready_i)

  // black reading gives zero hue and saturation and no class
  `RHCC_ASSERT_IMP(a_black, clk_i, rst_ni, out_valid_i && value_i == '0, hue_i == '0 && saturation_i == '0 && color_class_i == CLS_NONE)

  // a class needs saturation of at least one half
  `RHCC_ASSERT_IMP(a_cls_sat, clk_i, rst_ni, out_valid_i && color_class_i != CLS_NONE, saturation_i >= 8'd127)

  // hue stays inside one turn
  `RHCC_ASSERT(a_hue_range, clk_i, rst_ni, !out_valid_i || hue_i < 13'd5760)

endmodule

bind rgb_hsv_color_classifier_unit rhcc_checker u_rhcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .hue_i         (out_o.hue),
  .saturation_i  (out_o.saturation),
  .value_i       (out_o.value),
  .color_class_i (out_o.color_class)
);
